// ===== rtl/atc_pkg.sv =====
// ----------------------------------------------------------------------------
// atc_pkg: shared types and constants of the text console
// Geometry, parser phases, sequencer states and the ANSI-to-VGA colour map.
// ----------------------------------------------------------------------------
package atc_pkg;
   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int MAX_PARAMS = 8;
   localparam int CELLS      = ROWS * COLS;
   localparam int AW         = $clog2(CELLS);
   localparam int CW         = 7;
   localparam int RW         = 5;
   localparam int PW         = $clog2(MAX_PARAMS);

   // Reciprocals that turn a 16-bit value divided by COLS or ROWS into a
   // multiply and a shift; exact for every 16-bit numerator.
   localparam int COL_RECIP  = 104858;
   localparam int COL_SHIFT  = 23;
   localparam int ROW_RECIP  = 83887;
   localparam int ROW_SHIFT  = 21;

   localparam logic [7:0] ESC_BYTE   = 8'h1b;
   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [15:0] BLANK_RST = 16'h0720;

   typedef enum logic [1:0] {
      PH_IDLE, PH_ESC, PH_START, PH_PARAM
   } phase_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DECIDE, ST_RDWAIT, ST_RDOUT, ST_FILL,
      ST_SCR_RD, ST_SCR_WR, ST_SGR, ST_RESP
   } state_type;

   // A memory operation request from the sequencer to the cell store.
   typedef struct packed {
      logic            wr_en;
      logic [AW-1:0]   wr_addr;
      logic [15:0]     wr_data;
      logic [AW-1:0]   rd_addr;
   } mem_req_type;

   function automatic logic [3:0] ansi_to_vga(input logic [2:0] c);
      case (c)
         3'd0: ansi_to_vga = 4'h0;
         3'd1: ansi_to_vga = 4'h4;
         3'd2: ansi_to_vga = 4'h2;
         3'd3: ansi_to_vga = 4'h6;
         3'd4: ansi_to_vga = 4'h1;
         3'd5: ansi_to_vga = 4'h5;
         3'd6: ansi_to_vga = 4'h3;
         default: ansi_to_vga = 4'h7;
      endcase
   endfunction
endpackage

// ===== rtl/atc_if.sv =====
// ----------------------------------------------------------------------------
// atc_req_if / atc_rsp_if: valid/ready channels of the text console
// Request words carry a byte or a cell read; response words carry results.
// ----------------------------------------------------------------------------
interface atc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_in;
   logic [10:0] cell_index;
   modport source (output valid, kind, byte_in, cell_index, input ready);
   modport sink   (input valid, kind, byte_in, cell_index, output ready);
endinterface

interface atc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_char;
   logic [7:0] cell_attr;
   logic [6:0] cursor_col;
   logic [4:0] cursor_row;
   logic       seq_error;
   modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row,
                   seq_error, input ready);
   modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row,
                   seq_error, output ready);
endinterface

// ===== rtl/atc_cell_ram.sv =====
// ----------------------------------------------------------------------------
// atc_cell_ram: screen cell store
// One write port and one registered read port, 16-bit cells.
// ----------------------------------------------------------------------------
module atc_cell_ram
   import atc_pkg::*;
(
   input  logic        clock,
   input  mem_req_type req,
   output logic [15:0] rd_data
);
   logic [15:0] mem [CELLS];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data <= mem[req.rd_addr];
   end
endmodule

// ===== rtl/ansi_text_console_top.sv =====
// ----------------------------------------------------------------------------
// ansi_text_console_top: ANSI escape text-mode terminal over an 80x25 store
// Byte parser, cursor logic and a sequencer that owns the cell memory.
// ----------------------------------------------------------------------------
// After reset the block blanks all CELLS (2000) cells and takes no word
// meanwhile. A cell read passes the decode, read-wait and read-out states;
// a printable byte, CR or cursor sequence goes from decode to the response
// unless a wrap on the last row scrolls. A clear writes one cell per fill
// step; a scroll moves each cell through a read and a write state, since
// every cell of the move goes through the single read port and the single
// write port of the memory. Each item yields one response word, held in an
// output register until the sink takes it, before the next is accepted.
module ansi_text_console_top
   import atc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   atc_req_if.sink   req,
   atc_rsp_if.source rsp
);
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [CW-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [RW-1:0] row_ff, row_in, srow_ff, srow_in;
   logic [7:0]    attr_ff, attr_in;
   logic [15:0]   prm_ff [MAX_PARAMS];
   logic [15:0]   prm_in [MAX_PARAMS];
   logic [PW-1:0] pcnt_ff, pcnt_in;

   logic          kind_ff;
   logic [7:0]    byte_ff;
   logic [10:0]   idx_ff;
   logic          had_ff;

   // Fill / scroll walker.
   logic [AW-1:0] ptr_ff, ptr_in, end_ff, end_in;
   logic [RW:0]   scnt_ff, scnt_in;

   logic [PW:0]   sidx_ff, sidx_in;
   logic [7:0]    sattr_ff, sattr_in;

   logic [7:0]    och_ff, och_in, oat_ff, oat_in;
   logic          oerr_ff, oerr_in;

   mem_req_type   mreq;
   logic [15:0]   rd_data;

   atc_cell_ram u_ram (.clock(clock), .req(mreq), .rd_data(rd_data));

   logic [AW-1:0] cur_addr, row_base;
   assign row_base = AW'(row_ff * COLS);
   assign cur_addr = AW'(row_base + AW'(col_ff));

   logic [15:0] v0, v1;
   assign v0 = prm_ff[0];
   assign v1 = prm_ff[1];
   logic [15:0] blank;
   assign blank = {attr_ff, 8'h20};

   // Quotients of the first two parameters by COLS and ROWS. The parameter
   // store only changes at the end of a decode, and every decode is preceded
   // by at least the idle state, so the registered quotients are always
   // current when H or G is decoded.
   logic [32:0]           col_prod, row_prod;
   logic [32-COL_SHIFT:0] qcol_ff;
   logic [32-ROW_SHIFT:0] qrow_ff;
   logic [15:0]           hcol_rem, hrow_rem;
   assign col_prod = 33'(v0) * 33'(COL_RECIP);
   assign row_prod = 33'(v1) * 33'(ROW_RECIP);
   assign hcol_rem = v0 - 16'(int'(qcol_ff) * COLS);
   assign hrow_rem = v1 - 16'(int'(qrow_ff) * ROWS);

   // Next-state and datapath of the sequencer.
   always_comb begin
      logic [15:0] vs, va, vb;
      logic [PW:0] n;
      logic [19:0] nv;
      logic [PW-1:0] p;
      logic [15:0] d;
      logic [3:0] cv;
      state_in = state_ff;
      phase_in = phase_ff;
      col_in = col_ff; row_in = row_ff; scol_in = scol_ff; srow_in = srow_ff;
      attr_in = attr_ff;
      for (int i = 0; i < MAX_PARAMS; i++) prm_in[i] = prm_ff[i];
      pcnt_in = pcnt_ff;
      ptr_in = ptr_ff; end_in = end_ff; scnt_in = scnt_ff;
      sidx_in = sidx_ff; sattr_in = sattr_ff;
      och_in = och_ff; oat_in = oat_ff; oerr_in = oerr_ff;
      mreq.wr_en = 1'b0; mreq.wr_addr = ptr_ff; mreq.wr_data = blank;
      mreq.rd_addr = idx_ff[AW-1:0];
      n = (PW+1)'(pcnt_ff) + 1'b1;
      vs = 16'd0; va = 16'd0; vb = 16'd0; nv = 20'd0; p = '0; d = 16'd0;
      cv = 4'd0;
      unique case (state_ff)
         ST_INIT: begin
            mreq.wr_en = 1'b1; mreq.wr_data = BLANK_RST;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid) state_in = ST_DECIDE;
            och_in = 8'd0; oat_in = 8'd0; oerr_in = 1'b0;
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            if (kind_ff) begin
               state_in = ST_RDWAIT;
            end else if (phase_ff == PH_ESC) begin
               if (byte_ff == "[") begin
                  phase_in = PH_START;
                  for (int i = 0; i < MAX_PARAMS; i++) prm_in[i] = 16'd0;
                  pcnt_in = '0;
               end else begin
                  phase_in = PH_IDLE; oerr_in = 1'b1;
               end
            end else if (phase_ff == PH_START || phase_ff == PH_PARAM) begin
               if (byte_ff >= "0" && byte_ff <= "9") begin
                  p = pcnt_ff;
                  nv = 20'(prm_ff[p]) * 20'd10 + 20'(byte_ff - "0");
                  prm_in[p] = (nv > 20'hffff) ? 16'hffff : nv[15:0];
                  phase_in = PH_PARAM;
               end else if (byte_ff == ";" && phase_ff == PH_PARAM) begin
                  if (32'(pcnt_ff) + 1 >= MAX_PARAMS) begin
                     phase_in = PH_IDLE; oerr_in = 1'b1;
                  end else begin
                     pcnt_in = pcnt_ff + 1'b1;
                  end
               end else begin
                  phase_in = PH_IDLE;
                  if (!had_ff) begin
                     if (byte_ff == "s") begin
                        scol_in = col_ff; srow_in = row_ff;
                     end else if (byte_ff == "u") begin
                        col_in = scol_ff; row_in = srow_ff;
                     end else oerr_in = 1'b1;
                  end else if (byte_ff == "m") begin
                     sidx_in = '0; sattr_in = attr_ff; state_in = ST_SGR;
                  end else if (n > 1) begin
                     if (byte_ff == "H" && n == 2) begin
                        col_in = CW'(hcol_rem); row_in = RW'(hrow_rem);
                     end else oerr_in = 1'b1;
                  end else begin
                     case (byte_ff)
                        "K", "J": begin
                           if (v0 > 16'd2) oerr_in = 1'b1;
                           else begin
                              state_in = ST_FILL;
                              ptr_in = (v0 == 16'd0) ? cur_addr :
                                       (byte_ff == "K" ? row_base : '0);
                              end_in = (v0 == 16'd1) ? AW'(cur_addr + 1'b1) :
                                       (byte_ff == "K" ? AW'(row_base + COLS)
                                                       : AW'(CELLS));
                              if (byte_ff == "J" && v0 == 16'd0)
                                 end_in = AW'(CELLS);
                              if (byte_ff == "J" && v0 == 16'd2) begin
                                 ptr_in = '0; end_in = AW'(CELLS);
                                 col_in = '0; row_in = '0;
                              end
                              if (byte_ff == "K" && v0 == 16'd2) begin
                                 ptr_in = row_base; end_in = AW'(row_base + COLS);
                              end
                           end
                        end
                        "S": begin
                           vs = (v0 > 16'(ROWS)) ? 16'(ROWS) : v0;
                           if (vs != 16'd0) begin
                              scnt_in = (RW+1)'(vs); ptr_in = '0;
                              state_in = ST_SCR_RD;
                           end
                        end
                        "T": ;
                        "A", "F": begin
                           if (byte_ff == "F") col_in = '0;
                           va = (v0 < 16'(row_ff)) ? v0 : 16'(row_ff);
                           row_in = RW'(16'(row_ff) - va);
                        end
                        "B", "E": begin
                           if (byte_ff == "E") col_in = '0;
                           d = 16'(ROWS - 1) - 16'(row_ff);
                           vb = (v0 < d) ? v0 : d;
                           row_in = RW'(16'(row_ff) + vb);
                        end
                        "C": begin
                           d = 16'(COLS - 1) - 16'(col_ff);
                           vb = (v0 < d) ? v0 : d;
                           col_in = CW'(16'(col_ff) + vb);
                        end
                        "D": begin
                           va = (v0 < 16'(col_ff)) ? v0 : 16'(col_ff);
                           col_in = CW'(16'(col_ff) - va);
                        end
                        "G": col_in = CW'(hcol_rem);
                        default: oerr_in = 1'b1;
                     endcase
                  end
               end
            end else begin
               phase_in = PH_IDLE;
               if (byte_ff == 8'h0a) begin
                  ptr_in = cur_addr; end_in = AW'(row_base + COLS);
                  col_in = '0;
                  state_in = ST_FILL;
                  if (row_ff == RW'(ROWS - 1)) begin
                     scnt_in = (RW+1)'(1); // scroll after the blank
                  end else begin
                     scnt_in = '0; row_in = row_ff + 1'b1;
                  end
               end else if (byte_ff == 8'h0d) begin
                  col_in = '0;
               end else if (byte_ff == ESC_BYTE) begin
                  phase_in = PH_ESC;
               end else if (byte_ff != 8'h00) begin
                  mreq.wr_en = 1'b1; mreq.wr_addr = cur_addr;
                  mreq.wr_data = {attr_ff, byte_ff};
                  if (col_ff == CW'(COLS - 1)) begin
                     col_in = '0;
                     if (row_ff == RW'(ROWS - 1)) begin
                        scnt_in = (RW+1)'(1); ptr_in = '0; state_in = ST_SCR_RD;
                     end else row_in = row_ff + 1'b1;
                  end else col_in = col_ff + 1'b1;
               end
            end
         end
         ST_RDWAIT: state_in = ST_RDOUT;
         ST_RDOUT: begin
            if (idx_ff < 11'(CELLS)) begin
               och_in = rd_data[7:0]; oat_in = rd_data[15:8];
            end
            state_in = ST_RESP;
         end
         ST_FILL: begin
            mreq.wr_en = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (AW'(ptr_ff + 1'b1) == end_ff) begin
               if (scnt_ff != '0) begin
                  ptr_in = '0; state_in = ST_SCR_RD;
               end else state_in = ST_RESP;
            end
         end
         ST_SCR_RD: begin
            // Read the cell one row below; blank the last row.
            mreq.rd_addr = AW'(ptr_ff + COLS);
            if (ptr_ff >= AW'(CELLS - COLS)) begin
               end_in = AW'(CELLS); scnt_in = scnt_ff - 1'b1;
               state_in = ST_FILL;
            end else state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            mreq.wr_en = 1'b1; mreq.wr_data = rd_data;
            ptr_in = ptr_ff + 1'b1;
            state_in = ST_SCR_RD;
         end
         ST_SGR: begin
            p = sidx_ff[PW-1:0];
            vs = prm_ff[p];
            if (sidx_ff >= n) begin
               attr_in = sattr_ff; state_in = ST_RESP;
            end else if (vs >= 30 && vs <= 37) begin
               sattr_in = {sattr_ff[7:4], ansi_to_vga(vs[2:0] - 3'd6)};
               sidx_in = sidx_ff + 1'b1;
            end else if (vs == 39) begin
               sattr_in = {sattr_ff[7:4], 4'h7}; sidx_in = sidx_ff + 1'b1;
            end else if (vs >= 40 && vs <= 47) begin
               sattr_in = {ansi_to_vga(vs[2:0]), sattr_ff[3:0]};
               sidx_in = sidx_ff + 1'b1;
            end else if (vs == 49) begin
               sattr_in = {4'h0, sattr_ff[3:0]}; sidx_in = sidx_ff + 1'b1;
            end else if (vs == 38 || vs == 48) begin
               if (32'(sidx_ff) + 2 >= 32'(n)) begin
                  oerr_in = 1'b1; state_in = ST_RESP;
               end else if (prm_ff[PW'(sidx_ff + 1'b1)] == 16'd5) begin
                  va = prm_ff[PW'(sidx_ff + 2'd2)];
                  if (va > 16'd15) begin
                     oerr_in = 1'b1; state_in = ST_RESP;
                  end else begin
                     // Bright colours carry the intensity bit above the map.
                     cv = ansi_to_vga(va[2:0]);
                     if (vs == 38) sattr_in = {sattr_ff[7:4], va[3], cv[2:0]};
                     else sattr_in = {va[3], cv[2:0], sattr_ff[3:0]};
                     sidx_in = sidx_ff + 2'd3;
                  end
               end else sidx_in = sidx_ff + 2'd2;
            end else if (vs == 0 && sidx_ff + 1'b1 == n) begin
               sattr_in = RESET_ATTR; sidx_in = sidx_ff + 1'b1;
            end else begin
               oerr_in = 1'b1; state_in = ST_RESP;
            end
         end
         ST_RESP: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_RESP);
      rsp.cell_char = och_ff; rsp.cell_attr = oat_ff;
      rsp.cursor_col = col_ff; rsp.cursor_row = row_ff;
      rsp.seq_error = oerr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; phase_ff <= PH_IDLE;
         col_ff <= '0; row_ff <= '0; scol_ff <= '0; srow_ff <= '0;
         attr_ff <= RESET_ATTR; pcnt_ff <= '0; ptr_ff <= '0; scnt_ff <= '0;
         for (int i = 0; i < MAX_PARAMS; i++) prm_ff[i] <= 16'd0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in;
         col_ff <= col_in; row_ff <= row_in; scol_ff <= scol_in; srow_ff <= srow_in;
         attr_ff <= attr_in; pcnt_ff <= pcnt_in; ptr_ff <= ptr_in; scnt_ff <= scnt_in;
         for (int i = 0; i < MAX_PARAMS; i++) prm_ff[i] <= prm_in[i];
      end
      end_ff <= end_in; sidx_ff <= sidx_in; sattr_ff <= sattr_in;
      och_ff <= och_in; oat_ff <= oat_in; oerr_ff <= oerr_in;
      qcol_ff <= col_prod[32:COL_SHIFT];
      qrow_ff <= row_prod[32:ROW_SHIFT];
      if (req.valid && req.ready) begin
         kind_ff <= req.kind; byte_ff <= req.byte_in; idx_ff <= req.cell_index;
         had_ff <= (phase_ff == PH_PARAM);
      end
   end

   // No request is accepted in the fill or scroll-read walk states.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL || state_ff == ST_SCR_RD) |-> !req.ready)
      else $error("request taken during a memory walk");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.cursor_col))
      else $error("response dropped");
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.cursor_col < 7'(COLS) && rsp.cursor_row < 5'(ROWS)))
      else $error("cursor out of range");
endmodule
